### hw/rtl/pulse_half_max_width_defines.svh
`ifndef PULSE_HALF_MAX_WIDTH_DEFINES_SVH
`define PULSE_HALF_MAX_WIDTH_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PHMW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define PHMW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/phmw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phmw_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int TIME_W          = 32;
    localparam int VOLT_W          = 16;
    localparam int SEP_W           = 31;
    localparam int WIDTH_W         = 31;
    localparam int OIDX_W          = 10;
    localparam int LEVEL_W         = 17;
    localparam int DIST_W          = 17;
    localparam int TDIFF_W         = TIME_W + 1;

    localparam logic [SEP_W-1:0]   SEP_RESET = SEP_W'(1000);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2,
        ST_DIFF,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic busy;
    } t_back_status;

endpackage

`default_nettype wire

### hw/rtl/phmw_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface phmw_in_if
    import phmw_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TIME_W-1:0] sample_time;
    logic signed [VOLT_W-1:0] sample_volt;
    logic signed [VOLT_W-1:0] peak_max;
    logic signed [VOLT_W-1:0] peak_min;
    logic                     last_sample;

    modport source (output valid, sample_time, sample_volt, peak_max, peak_min, last_sample,
                    input ready);
    modport sink   (input valid, sample_time, sample_volt, peak_max, peak_min, last_sample,
                    output ready);
endinterface

interface phmw_out_if
    import phmw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] width;
    logic [OIDX_W-1:0]  half_index;
    logic [OIDX_W-1:0]  partner_index;
    logic               no_partner;

    modport source (output valid, width, half_index, partner_index, no_partner, input ready);
    modport sink   (input valid, width, half_index, partner_index, no_partner, output ready);
endinterface

`default_nettype wire

### hw/rtl/pulse_half_max_width.sv
// Pulse width at half level. Samples (time, voltage) load into a buffer of
// MAX_SAMPLES entries at one per cycle while no search is queued or running;
// samples past a full buffer are dropped. The request flagged last_sample also
// carries the event peaks and starts the search: pass one scans the N stored
// samples for the one closest to (peak_max - peak_min)/2, pass two scans them
// again for the sample beyond min_separation closest in voltage to it, and the
// result goes to an output register. The search reads the buffer one sample
// per cycle through the single read port, and no sample is taken during it;
// it stalls in its emit state only while an earlier result still waits on the
// output. A new waveform may load while a finished result waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module pulse_half_max_width
    import phmw_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [SEP_W-1:0] i_cfg_wdata,
    phmw_in_if.sink               i_in,
    phmw_out_if.source            o_out
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = $clog2(MAX_SAMPLES);

    logic [SEP_W-1:0]        r_min_sep;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [TIME_W-1:0]       wr_time;
    logic [VOLT_W-1:0]       wr_volt;
    logic                    push;
    logic                    pop;
    logic [CW+LEVEL_W-1:0]   job_in;
    logic [CW+LEVEL_W-1:0]   job_out;
    t_q_status               q_status;
    t_back_status            back_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sep <= SEP_RESET;
        end else if (i_cfg_we) begin
            r_min_sep <= i_cfg_wdata;
        end
    end

    phmw_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .IW          (IW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_q_status    (q_status),
        .i_back_status (back_status),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_time     (wr_time),
        .o_wr_volt     (wr_volt),
        .o_push        (push),
        .o_job         (job_in)
    );

    phmw_queue #(
        .W (CW + LEVEL_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (job_in),
        .i_pop    (pop),
        .o_data   (job_out),
        .o_status (q_status)
    );

    phmw_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW),
        .IW          (IW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_sep  (r_min_sep),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_time  (wr_time),
        .i_wr_volt  (wr_volt),
        .i_q_status (q_status),
        .i_job      (job_out),
        .o_pop      (pop),
        .o_status   (back_status),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

### hw/rtl/phmw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_half_max_width_defines.svh"

module phmw_queue
    import phmw_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output t_q_status         o_status
);

    logic [W-1:0] r_data [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_count;
    logic [1:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && r_count != 2'd0)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && r_count != 2'd0) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && r_count != 2'd0) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    assign o_data             = r_data[r_rp];
    assign o_status.not_empty = (r_count != 2'd0);
    assign o_status.full      = (r_count == 2'd2);

    `PHMW_ASSERT_IMPL(a_no_push_full, i_push, !o_status.full, "job pushed into full queue")

endmodule

`default_nettype wire

### hw/rtl/phmw_front.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_half_max_width_defines.svh"

module phmw_front
    import phmw_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int CW          = $clog2(MAX_SAMPLES + 1),
    parameter int IW          = $clog2(MAX_SAMPLES)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    phmw_in_if.sink             i_in,
    input  wire t_q_status      i_q_status,
    input  wire t_back_status   i_back_status,
    output logic                o_wr_en,
    output logic [IW-1:0]       o_wr_addr,
    output logic [TIME_W-1:0]   o_wr_time,
    output logic [VOLT_W-1:0]   o_wr_volt,
    output logic                o_push,
    output logic [CW+LEVEL_W-1:0] o_job
);

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic [CW-1:0]      cnt_after;
    logic               ready;
    logic               acc;
    logic               has_room;
    logic [LEVEL_W-1:0] level;

    assign ready    = !i_q_status.not_empty && !i_back_status.busy;
    assign acc      = i_in.valid && ready;
    assign has_room = (r_cnt < CW'(MAX_SAMPLES));

    assign i_in.ready = ready;
    assign o_wr_en    = acc && has_room;
    assign o_wr_addr  = r_cnt[IW-1:0];
    assign o_wr_time  = i_in.sample_time;
    assign o_wr_volt  = i_in.sample_volt;

    // doubled half level, max minus min
    assign level = {i_in.peak_max[VOLT_W-1], i_in.peak_max}
                 - {i_in.peak_min[VOLT_W-1], i_in.peak_min};

    assign cnt_after = has_room ? (r_cnt + CW'(1)) : r_cnt;
    assign o_push    = acc && i_in.last_sample;
    assign o_job     = {cnt_after, level};

    always_comb begin
        n_cnt = r_cnt;
        if (acc) begin
            n_cnt = i_in.last_sample ? '0 : cnt_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `PHMW_ASSERT_NEXT(a_lock_after_last, o_push, !ready, "sample taken while a search is queued")

endmodule

`default_nettype wire

### hw/rtl/phmw_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_half_max_width_defines.svh"

module phmw_back
    import phmw_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int CW          = $clog2(MAX_SAMPLES + 1),
    parameter int IW          = $clog2(MAX_SAMPLES)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [SEP_W-1:0]      i_min_sep,
    input  wire logic                  i_wr_en,
    input  wire logic [IW-1:0]         i_wr_addr,
    input  wire logic [TIME_W-1:0]     i_wr_time,
    input  wire logic [VOLT_W-1:0]     i_wr_volt,
    input  wire t_q_status             i_q_status,
    input  wire logic [CW+LEVEL_W-1:0] i_job,
    output logic                       o_pop,
    output t_back_status               o_status,
    phmw_out_if.source                 o_out
);

    logic [TIME_W-1:0] r_mem_time [MAX_SAMPLES];
    logic [VOLT_W-1:0] r_mem_volt [MAX_SAMPLES];

    t_back_state        r_state;
    t_back_state        n_state;
    logic [CW-1:0]      r_cnt;
    logic [LEVEL_W-1:0] r_level;
    logic [CW-1:0]      r_addr;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    logic [TIME_W-1:0]  r_rd_time;
    logic [VOLT_W-1:0]  r_rd_volt;
    logic               r_found;
    logic [DIST_W-1:0]  r_best_dist;
    logic [IW-1:0]      r_best_idx;
    logic [TIME_W-1:0]  r_best_time;
    logic [VOLT_W-1:0]  r_best_volt;
    logic [IW-1:0]      r_half_idx;
    logic [TIME_W-1:0]  r_t_half;
    logic [VOLT_W-1:0]  r_v_half;
    logic [TDIFF_W-1:0] r_wdiff;
    logic               r_out_vld;
    logic [WIDTH_W-1:0] r_out_width;
    logic [OIDX_W-1:0]  r_out_half;
    logic [OIDX_W-1:0]  r_out_partner;
    logic               r_out_none;

    logic               in_pass;
    logic               rd_en;
    logic               pass_done;
    logic               out_load;
    logic [LEVEL_W:0]   p1_diff;
    logic [LEVEL_W:0]   p1_abs;
    logic [DIST_W-1:0]  p2_diff;
    logic [DIST_W-1:0]  p2_abs;
    logic [DIST_W-1:0]  cand_dist;
    logic [TDIFF_W-1:0] t_diff;
    logic [TDIFF_W-1:0] sep_pos;
    logic [TDIFF_W-1:0] sep_neg;
    logic               qualify;
    logic               take;
    logic [TDIFF_W-1:0] w_abs;
    logic [WIDTH_W-1:0] w_sat;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_status.not_empty) begin
                    n_state = ST_PASS1;
                end
            end
            ST_PASS1: begin
                if (pass_done) begin
                    n_state = ST_PASS2;
                end
            end
            ST_PASS2: begin
                if (pass_done) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        in_pass   = 1'b0;
        o_pop     = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = i_q_status.not_empty;
            end
            ST_PASS1, ST_PASS2: begin
                in_pass = 1'b1;
            end
            ST_EMIT: begin
                out_load = !r_out_vld || o_out.ready;
            end
            default: begin
                in_pass = 1'b0;
            end
        endcase
    end

    assign rd_en     = in_pass && (r_addr < r_cnt);
    assign pass_done = in_pass && (r_addr == r_cnt) && !r_rd_vld;

    // distance to the half level, doubled
    assign p1_diff = {r_level[LEVEL_W-1], r_level} - {r_rd_volt[VOLT_W-1], r_rd_volt, 1'b0};
    assign p1_abs  = p1_diff[LEVEL_W] ? (~p1_diff + 1'b1) : p1_diff;

    // distance to the half sample voltage
    assign p2_diff = {r_v_half[VOLT_W-1], r_v_half} - {r_rd_volt[VOLT_W-1], r_rd_volt};
    assign p2_abs  = p2_diff[DIST_W-1] ? (~p2_diff + 1'b1) : p2_diff;

    // time gap test against min separation
    assign t_diff  = {r_rd_time[TIME_W-1], r_rd_time} - {r_t_half[TIME_W-1], r_t_half};
    assign sep_pos = {2'b00, i_min_sep};
    assign sep_neg = ~sep_pos + 1'b1;
    assign qualify = ($signed(t_diff) > $signed(sep_pos)) || ($signed(t_diff) < $signed(sep_neg));

    assign cand_dist = (r_state == ST_PASS1) ? p1_abs[DIST_W-1:0] : p2_abs;
    assign take = r_rd_vld && ((r_state == ST_PASS1) || qualify)
               && (!r_found || cand_dist < r_best_dist);

    assign w_abs = r_wdiff[TDIFF_W-1] ? (~r_wdiff + 1'b1) : r_wdiff;
    assign w_sat = (w_abs > TDIFF_W'(WIDTH_MAX)) ? WIDTH_MAX : w_abs[WIDTH_W-1:0];

    // sample buffer
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_time[i_wr_addr] <= i_wr_time;
            r_mem_volt[i_wr_addr] <= i_wr_volt;
        end
        if (rd_en) begin
            r_rd_time <= r_mem_time[r_addr[IW-1:0]];
            r_rd_volt <= r_mem_volt[r_addr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (o_pop || (r_state == ST_PASS1 && pass_done)) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cnt   <= i_job[CW+LEVEL_W-1:LEVEL_W];
            r_level <= i_job[LEVEL_W-1:0];
            r_addr  <= '0;
        end else if (pass_done) begin
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + CW'(1);
        end
        if (rd_en) begin
            r_rd_idx <= r_addr[IW-1:0];
        end
        if (take) begin
            r_best_dist <= cand_dist;
            r_best_idx  <= r_rd_idx;
            r_best_time <= r_rd_time;
            r_best_volt <= r_rd_volt;
        end
        if (r_state == ST_PASS1 && pass_done) begin
            r_half_idx <= r_best_idx;
            r_t_half   <= r_best_time;
            r_v_half   <= r_best_volt;
        end
        if (r_state == ST_DIFF) begin
            r_wdiff <= {r_best_time[TIME_W-1], r_best_time} - {r_t_half[TIME_W-1], r_t_half};
        end
        if (out_load) begin
            r_out_half    <= OIDX_W'(r_half_idx);
            r_out_partner <= r_found ? OIDX_W'(r_best_idx) : '0;
            r_out_width   <= r_found ? w_sat : '0;
            r_out_none    <= !r_found;
        end
    end

    assign o_status.busy       = (r_state != ST_IDLE);
    assign o_out.valid         = r_out_vld;
    assign o_out.width         = r_out_width;
    assign o_out.half_index    = r_out_half;
    assign o_out.partner_index = r_out_partner;
    assign o_out.no_partner    = r_out_none;

    `PHMW_ASSERT_IMPL(a_rd_in_pass, r_rd_vld, in_pass, "read data outside a pass")
    `PHMW_ASSERT_IMPL(a_addr_bound, in_pass, (r_addr <= r_cnt), "scan address beyond sample count")
    `PHMW_ASSERT_IMPL(a_partner_differs, (r_state == ST_DIFF && r_found),
                      (r_best_idx != r_half_idx), "partner equals half sample")

endmodule

`default_nettype wire
